// ===== src/bmsc_pkg.sv =====
package bmsc_pkg;

    // bus operations
    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_FETCH = 3'd2;
    localparam logic [2:0] OP_CTRL  = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;

    // system-control codes
    localparam logic [7:0] CC_BOOT_ON   = 8'h00;
    localparam logic [7:0] CC_BOOT_OFF  = 8'h01;
    localparam logic [7:0] CC_ROM_ON    = 8'h02;
    localparam logic [7:0] CC_ROM_OFF   = 8'h03;
    localparam logic [7:0] CC_DRV0_CLR  = 8'h04;
    localparam logic [7:0] CC_DRV0_SET  = 8'h05;
    localparam logic [7:0] CC_DRV1_CLR  = 8'h06;
    localparam logic [7:0] CC_DRV1_SET  = 8'h07;
    localparam logic [7:0] CC_DRV2_CLR  = 8'h08;
    localparam logic [7:0] CC_DRV2_SET  = 8'h09;
    localparam logic [7:0] CC_SIDE0     = 8'h0A;
    localparam logic [7:0] CC_SIDE1     = 8'h0B;
    localparam logic [7:0] CC_MOTOR0    = 8'h0C;
    localparam logic [7:0] CC_MOTOR1    = 8'h0D;
    localparam logic [7:0] CC_FDC_RESET = 8'h0E;
    localparam logic [7:0] CC_NMI_ARM   = 8'h80;

    localparam logic [15:0] ROM_BASE    = 16'hC000;
    localparam logic [1:0]  NMI_ARM_CNT = 2'd3;
    localparam logic [7:0]  ROM_BLANK   = 8'hFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
    } in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi_fire;
        logic       drive_reg_valid;
        logic [1:0] drive_reg_value;
        logic       drive_lines_valid;
        logic [3:0] drive_lines;
        logic       side_valid;
        logic       side_value;
        logic       motor_valid;
        logic       motor_value;
        logic       fdc_reset;
    } out_t;

    // memory access request for one accepted transaction
    typedef struct packed {
        logic        ram_we;
        logic        rom_we;
        logic        rd_en;
        logic        rom_sel;
        logic [15:0] ram_addr;
        logic [13:0] rom_waddr;
        logic [13:0] rom_raddr;
        logic [7:0]  wdata;
    } mem_req_t;

endpackage

// ===== src/bmsc_decode.sv =====
module bmsc_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              acc,
    input  bmsc_pkg::in_t     item,
    output bmsc_pkg::mem_req_t req,
    output bmsc_pkg::out_t    res
);

    logic       boot_high_reg, boot_high_next;
    logic       rom_en_reg, rom_en_next;
    logic [2:0] latch_reg, latch_next;
    logic [1:0] nmi_cnt_reg, nmi_cnt_next;

    logic [15:0] ea;
    logic [7:0]  dsub;
    logic [2:0]  dmask;

    assign ea    = item.addr | (boot_high_reg ? bmsc_pkg::ROM_BASE : 16'h0000);
    assign dsub  = item.data - bmsc_pkg::CC_DRV0_CLR;
    assign dmask = 3'b001 << dsub[2:1];

    always_comb begin
        boot_high_next = boot_high_reg;
        rom_en_next    = rom_en_reg;
        latch_next     = latch_reg;
        nmi_cnt_next   = nmi_cnt_reg;
        res            = '0;

        req           = '0;
        req.ram_addr  = ea;
        req.rom_waddr = item.addr[13:0];
        req.rom_raddr = ea[13:0];
        req.wdata     = item.data;
        req.rom_sel   = rom_en_reg && (ea[15:14] == 2'b11);

        unique case (item.op)
            bmsc_pkg::OP_READ: begin
                req.rd_en = acc;
            end
            bmsc_pkg::OP_WRITE: begin
                req.ram_we = acc;
            end
            bmsc_pkg::OP_FETCH: begin
                req.rd_en = acc;
                if (nmi_cnt_reg != 2'd0) begin
                    nmi_cnt_next = nmi_cnt_reg - 2'd1;
                    res.nmi_fire = (nmi_cnt_reg == 2'd1);
                end
            end
            bmsc_pkg::OP_CTRL: begin
                unique case (item.data)
                    bmsc_pkg::CC_BOOT_ON:  boot_high_next = 1'b1;
                    bmsc_pkg::CC_BOOT_OFF: boot_high_next = 1'b0;
                    bmsc_pkg::CC_ROM_ON:   rom_en_next    = 1'b1;
                    bmsc_pkg::CC_ROM_OFF:  rom_en_next    = 1'b0;
                    bmsc_pkg::CC_DRV0_CLR, bmsc_pkg::CC_DRV0_SET,
                    bmsc_pkg::CC_DRV1_CLR, bmsc_pkg::CC_DRV1_SET,
                    bmsc_pkg::CC_DRV2_CLR, bmsc_pkg::CC_DRV2_SET: begin
                        latch_next = item.data[0] ? (latch_reg | dmask)
                                                  : (latch_reg & ~dmask);
                        res.drive_reg_valid   = latch_next[2];
                        res.drive_reg_value   = latch_next[2] ? latch_next[1:0] : 2'd0;
                        res.drive_lines_valid = 1'b1;
                        // line k goes low when the latch selects drive 4+k
                        res.drive_lines = latch_next[2] ? ~(4'b0001 << latch_next[1:0])
                                                        : 4'hF;
                    end
                    bmsc_pkg::CC_SIDE0, bmsc_pkg::CC_SIDE1: begin
                        res.side_valid = 1'b1;
                        res.side_value = item.data[0];
                    end
                    bmsc_pkg::CC_MOTOR0, bmsc_pkg::CC_MOTOR1: begin
                        res.motor_valid = 1'b1;
                        res.motor_value = item.data[0];
                    end
                    bmsc_pkg::CC_FDC_RESET: res.fdc_reset = 1'b1;
                    bmsc_pkg::CC_NMI_ARM:   nmi_cnt_next  = bmsc_pkg::NMI_ARM_CNT;
                    default: ;
                endcase
            end
            bmsc_pkg::OP_LOAD: begin
                req.rom_we = acc && (item.addr[15:14] == 2'b11);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_high_reg <= 1'b1;
            rom_en_reg    <= 1'b1;
            latch_reg     <= 3'd0;
            nmi_cnt_reg   <= 2'd0;
        end else if (acc) begin
            boot_high_reg <= boot_high_next;
            rom_en_reg    <= rom_en_next;
            latch_reg     <= latch_next;
            nmi_cnt_reg   <= nmi_cnt_next;
        end
    end

    a_nmi_fire_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && res.nmi_fire) |=> (nmi_cnt_reg == 2'd0))
        else $error("nmi fired but countdown not empty");

    a_nmi_only_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        res.nmi_fire |-> (item.op == bmsc_pkg::OP_FETCH))
        else $error("nmi on non-fetch transaction");

    a_boot_forces_high: assert property (@(posedge aclk) disable iff (!aresetn)
        boot_high_reg |-> (req.ram_addr[15:14] == 2'b11))
        else $error("boot mode address not forced high");

endmodule

// ===== src/bmsc_mem.sv =====
module bmsc_mem (
    input  logic               aclk,
    input  logic               aresetn,
    input  bmsc_pkg::mem_req_t req,
    output logic               clr_busy,
    output logic [7:0]         ram_q,
    output logic [7:0]         rom_q
);

    logic [7:0]  main_ram_reg  [65536];
    logic [7:0]  rom_store_reg [16384];
    logic [7:0]  ram_q_reg;
    logic [7:0]  rom_q_reg;
    logic        clr_busy_reg;
    logic [15:0] clr_addr_reg;

    // power-up sweep: RAM to zero, ROM store to blank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= 16'd0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 16'd1;
            if (clr_addr_reg == 16'hFFFF) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            main_ram_reg[clr_addr_reg] <= 8'h00;
        end else if (req.ram_we) begin
            main_ram_reg[req.ram_addr] <= req.wdata;
        end
        if (req.rd_en) begin
            ram_q_reg <= main_ram_reg[req.ram_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            rom_store_reg[clr_addr_reg[13:0]] <= bmsc_pkg::ROM_BLANK;
        end else if (req.rom_we) begin
            rom_store_reg[req.rom_waddr] <= req.wdata;
        end
        if (req.rd_en) begin
            rom_q_reg <= rom_store_reg[req.rom_raddr];
        end
    end

    assign clr_busy = clr_busy_reg;
    assign ram_q    = ram_q_reg;
    assign rom_q    = rom_q_reg;

endmodule

// ===== src/banked_memory_system_control.sv =====
// Banked memory and system-control block of a small Z80-class machine.
// Input channel (s_valid/s_ready/s_data): one bus transaction per beat --
// memory read, memory write, opcode fetch, control I/O write or ROM load.
// Result channel (m_valid/m_ready/m_data): exactly one result transaction
// per input transaction, in order: read byte, NMI strobe and disk-controller
// strobes (drive register, drive lines, side, motor, reset).
// Pipeline: stage 1 is the registered read port of the RAM/ROM arrays (state
// updates happen at accept); stage 2 is the output register, which raises
// m_valid once stage 1 passes the transaction on. Throughput: 1 transaction
// per cycle while the receiver takes results and no sweep runs.
// Reset (aresetn low, synchronous): boot mode and ROM mapping on, drive
// latch and NMI countdown cleared. After reset a sweep over all 65536 addresses
// zeroes RAM and blanks the ROM store to 0xFF; s_ready stays low until done.
// Receiver stall: the output register holds; stage 1 still takes one more
// transaction, then s_ready drops until m_ready returns.
module banked_memory_system_control (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bmsc_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bmsc_pkg::out_t m_data
);

    bmsc_pkg::mem_req_t req;
    bmsc_pkg::out_t     res;
    bmsc_pkg::out_t     s1_res_reg;
    bmsc_pkg::out_t     s2_comb;
    bmsc_pkg::out_t     m_data_reg;
    logic               clr_busy;
    logic [7:0]         ram_q;
    logic [7:0]         rom_q;
    logic               acc;
    logic               s1_adv;
    logic               s1_valid_reg;
    logic               s1_rd_reg;
    logic               s1_rom_sel_reg;
    logic               m_valid_reg;

    // stage 1 moves on when the output register is empty or being drained
    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !clr_busy && (!s1_valid_reg || s1_adv);
    assign acc     = s_valid && s_ready;

    bmsc_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .acc     (acc),
        .item    (s_data),
        .req     (req),
        .res     (res)
    );

    bmsc_mem u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .clr_busy (clr_busy),
        .ram_q    (ram_q),
        .rom_q    (rom_q)
    );

    // stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage 1 payload; read data sits in the memory output registers
    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_res_reg     <= res;
            s1_rd_reg      <= req.rd_en;
            s1_rom_sel_reg <= req.rom_sel;
        end
    end

    always_comb begin
        s2_comb = s1_res_reg;
        if (s1_rd_reg) begin
            s2_comb.read_data = s1_rom_sel_reg ? rom_q : ram_q;
        end else begin
            s2_comb.read_data = 8'h00;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= s2_comb;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("transaction accepted during memory sweep");

    a_s1_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready) |=> s1_valid_reg)
        else $error("stage 1 transaction lost under stall");

    a_s1_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_adv) |=> m_valid_reg)
        else $error("stage 1 transaction not moved to output");

    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |=> s1_valid_reg)
        else $error("accepted transaction missing from stage 1");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // run limits
    localparam int RANDOM_TXNS = 1725;
    localparam int TAIL_TXNS   = 150;     // last stretch runs with no idling
    localparam int DRAIN_EVERY = 400;     // sender waits for all results this often
    localparam int CYCLE_LIMIT = 400000;  // covers the clearing sweep too
    localparam int MAX_REPORTS = 10;

    // pending bus transaction; drain makes the sender wait for an empty scoreboard
    typedef struct packed {
        logic          drain;
        bmsc_pkg::in_t txn;
    } stim_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    bmsc_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    bmsc_pkg::out_t m_data;

    stim_t          stim_q[$];
    bmsc_pkg::out_t want_q[$];
    int             err_cnt   = 0;
    int             cycle_cnt = 0;

    // shadow of the block's state
    logic [7:0] ram_img [0:65535];
    logic [7:0] rom_img [0:16383];
    logic       boot_hi;
    logic       rom_map;
    logic [2:0] drv_latch;
    logic [1:0] nmi_cnt;

    // every code the block decodes plus the unused code 0x0F, for picking control writes at random
    logic [7:0] ctrl_codes [0:16] = '{bmsc_pkg::CC_BOOT_ON, bmsc_pkg::CC_BOOT_OFF,
        bmsc_pkg::CC_ROM_ON, bmsc_pkg::CC_ROM_OFF,
        bmsc_pkg::CC_DRV0_CLR, bmsc_pkg::CC_DRV0_SET, bmsc_pkg::CC_DRV1_CLR,
        bmsc_pkg::CC_DRV1_SET, bmsc_pkg::CC_DRV2_CLR, bmsc_pkg::CC_DRV2_SET,
        bmsc_pkg::CC_SIDE0, bmsc_pkg::CC_SIDE1, bmsc_pkg::CC_MOTOR0, bmsc_pkg::CC_MOTOR1,
        bmsc_pkg::CC_FDC_RESET, bmsc_pkg::CC_NMI_ARM, 8'h0F};

    // address windows around the map boundaries, so reads hit earlier writes
    logic [15:0] hot_bases [0:6] = '{16'h0000, 16'h3FF0, 16'hBFF0, bmsc_pkg::ROM_BASE,
        16'hEFF8, 16'hF000, 16'hFFF0};

    banked_memory_system_control dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // byte seen by a read or fetch at effective address ea
    function automatic logic [7:0] mem_peek(logic [15:0] ea);
        if (rom_map && ea >= bmsc_pkg::ROM_BASE) begin
            return rom_img[ea[13:0]];
        end
        return ram_img[ea];
    endfunction

    // expected result of one bus transaction; updates the shadow state
    function automatic bmsc_pkg::out_t bus_result(bmsc_pkg::in_t t);
        bmsc_pkg::out_t r;
        logic [15:0]    ea;
        logic [2:0]     bit_sel;
        logic [7:0]     code_ofs;
        int             k;
        r  = '0;
        // boot mode folds every CPU address into the top 16K
        ea = t.addr | (boot_hi ? bmsc_pkg::ROM_BASE : 16'h0000);
        case (t.op)
            bmsc_pkg::OP_READ: begin
                r.read_data = mem_peek(ea);
            end
            bmsc_pkg::OP_WRITE: begin
                // writes land in RAM even where ROM is mapped
                ram_img[ea] = t.data;
            end
            bmsc_pkg::OP_FETCH: begin
                // an idle countdown stays at zero and never fires
                if (nmi_cnt != 2'd0) begin
                    nmi_cnt    = nmi_cnt - 2'd1;
                    r.nmi_fire = (nmi_cnt == 2'd0);
                end
                r.read_data = mem_peek(ea);
            end
            bmsc_pkg::OP_CTRL: begin
                case (t.data)
                    bmsc_pkg::CC_BOOT_ON:  boot_hi = 1'b1;
                    bmsc_pkg::CC_BOOT_OFF: boot_hi = 1'b0;
                    bmsc_pkg::CC_ROM_ON:   rom_map = 1'b1;
                    bmsc_pkg::CC_ROM_OFF:  rom_map = 1'b0;
                    bmsc_pkg::CC_DRV0_CLR, bmsc_pkg::CC_DRV0_SET, bmsc_pkg::CC_DRV1_CLR,
                    bmsc_pkg::CC_DRV1_SET, bmsc_pkg::CC_DRV2_CLR,
                    bmsc_pkg::CC_DRV2_SET: begin
                        // odd codes set, even codes clear one latch bit
                        code_ofs  = t.data - bmsc_pkg::CC_DRV0_CLR;
                        bit_sel   = 3'b001 << code_ofs[2:1];
                        drv_latch = t.data[0] ? (drv_latch | bit_sel)
                                              : (drv_latch & ~bit_sel);
                        if (drv_latch[2]) begin
                            r.drive_reg_valid = 1'b1;
                            r.drive_reg_value = drv_latch[1:0];
                        end
                        r.drive_lines_valid = 1'b1;
                        // active-low select line k for latch values 4..7
                        for (k = 0; k < 4; k++) begin
                            r.drive_lines[k] = (drv_latch != 3'(4 + k));
                        end
                    end
                    bmsc_pkg::CC_SIDE0, bmsc_pkg::CC_SIDE1: begin
                        r.side_valid = 1'b1;
                        r.side_value = t.data[0];
                    end
                    bmsc_pkg::CC_MOTOR0, bmsc_pkg::CC_MOTOR1: begin
                        r.motor_valid = 1'b1;
                        r.motor_value = t.data[0];
                    end
                    bmsc_pkg::CC_FDC_RESET: r.fdc_reset = 1'b1;
                    bmsc_pkg::CC_NMI_ARM:   nmi_cnt = bmsc_pkg::NMI_ARM_CNT;
                    default: ;    // unknown codes are ignored
                endcase
            end
            bmsc_pkg::OP_LOAD: begin
                // image bytes below the ROM window are dropped
                if (t.addr >= bmsc_pkg::ROM_BASE) begin
                    rom_img[t.addr[13:0]] = t.data;
                end
            end
            default: ;            // undefined ops: no effect, zero result
        endcase
        return r;
    endfunction

    function automatic string fmt_res(bmsc_pkg::out_t r);
        return $sformatf(
            "rd=%02h nmi=%b dreg=%b/%0d dlines=%b/%04b side=%b/%b motor=%b/%b fdcrst=%b",
            r.read_data, r.nmi_fire, r.drive_reg_valid, r.drive_reg_value,
            r.drive_lines_valid, r.drive_lines, r.side_valid, r.side_value,
            r.motor_valid, r.motor_value, r.fdc_reset);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_txn(logic [2:0] op, logic [15:0] addr, logic [7:0] data,
                             logic drain);
        stim_t s;
        s.drain     = drain;
        s.txn.op    = op;
        s.txn.addr  = addr;
        s.txn.data  = data;
        stim_q.push_back(s);
    endtask

    // half fully random, half clustered near the map boundaries
    function automatic logic [15:0] pick_addr();
        if ($urandom_range(0, 1) == 0) begin
            return 16'($urandom);
        end
        return hot_bases[$urandom_range(0, 6)] + 16'($urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 9) < 8) begin
            return ctrl_codes[$urandom_range(0, 16)];
        end
        return 8'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents stim_q on the input channel, predicts on accept
    // ------------------------------------------------------------------
    int   gap_left  = 0;
    logic idle_mode = 1'b1;

    always @(posedge aclk) begin
        stim_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                // transaction accepted: its result joins the scoreboard now
                want_q.push_back(bus_result(s_data));
                if ($urandom_range(0, 79) == 0) begin
                    idle_mode = ~idle_mode;
                end
                if (idle_mode && stim_q.size() > TAIL_TXNS && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(1, 3);
                end
            end
            // channel free: either nothing presented or the item just went through
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (stim_q.size() == 0 ||
                             (stim_q[0].drain && want_q.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    nxt      = stim_q.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= nxt.txn;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, in-order compare against want_q
    // ------------------------------------------------------------------
    int   stall_left = 0;
    logic stall_mode = 1'b1;

    always @(posedge aclk) begin
        bmsc_pkg::out_t exp_r;
        bmsc_pkg::out_t got_r;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                got_r = m_data;
                if (want_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("unexpected result transaction: %s", fmt_res(got_r));
                    end
                end else begin
                    exp_r = want_q.pop_front();
                    if (got_r.read_data         !== exp_r.read_data         ||
                        got_r.nmi_fire          !== exp_r.nmi_fire          ||
                        got_r.drive_reg_valid   !== exp_r.drive_reg_valid   ||
                        got_r.drive_reg_value   !== exp_r.drive_reg_value   ||
                        got_r.drive_lines_valid !== exp_r.drive_lines_valid ||
                        got_r.drive_lines       !== exp_r.drive_lines       ||
                        got_r.side_valid        !== exp_r.side_valid        ||
                        got_r.side_value        !== exp_r.side_value        ||
                        got_r.motor_valid       !== exp_r.motor_valid       ||
                        got_r.motor_value       !== exp_r.motor_value       ||
                        got_r.fdc_reset         !== exp_r.fdc_reset) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("result mismatch at cycle %0d", cycle_cnt);
                            $display("  expected: %s", fmt_res(exp_r));
                            $display("  actual:   %s", fmt_res(got_r));
                        end
                    end
                end
                if ($urandom_range(0, 79) == 0) begin
                    stall_mode = ~stall_mode;
                end
            end
            // random stall bursts, none once the tail is reached
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (stall_mode && stim_q.size() > TAIL_TXNS &&
                         $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_ready   <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int   i;
        int   r;
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;

        // shadow state after reset: RAM cleared, ROM blank, boot and ROM on
        for (i = 0; i < 65536; i++) ram_img[i] = 8'h00;
        for (i = 0; i < 16384; i++) rom_img[i] = bmsc_pkg::ROM_BLANK;
        boot_hi   = 1'b1;
        rom_map   = 1'b1;
        drv_latch = 3'd0;
        nmi_cnt   = 2'd0;

        // directed: blank ROM, image load in and below the window, boot folding
        queue_txn(bmsc_pkg::OP_READ,  16'h0000, 8'h00, 1'b0);
        queue_txn(bmsc_pkg::OP_LOAD,  16'h1234, 8'h55, 1'b0);
        queue_txn(bmsc_pkg::OP_LOAD,  16'hC000, 8'hA5, 1'b0);
        queue_txn(bmsc_pkg::OP_LOAD,  16'hFFFF, 8'h3C, 1'b0);
        queue_txn(bmsc_pkg::OP_FETCH, 16'h0000, 8'h00, 1'b0);  // countdown idle, no NMI
        queue_txn(bmsc_pkg::OP_WRITE, 16'h0001, 8'h77, 1'b0);  // lands at C001 in RAM
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, bmsc_pkg::CC_BOOT_OFF, 1'b0);
        queue_txn(bmsc_pkg::OP_CTRL,  16'hFFFF, bmsc_pkg::CC_ROM_OFF, 1'b0);
        queue_txn(bmsc_pkg::OP_READ,  16'hC001, 8'hFF, 1'b0);  // RAM under the ROM window
        // NMI: arm, then the third fetch fires
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, bmsc_pkg::CC_NMI_ARM, 1'b0);
        queue_txn(bmsc_pkg::OP_FETCH, 16'hFFFF, 8'h00, 1'b0);
        queue_txn(bmsc_pkg::OP_FETCH, 16'h0000, 8'h00, 1'b0);
        queue_txn(bmsc_pkg::OP_FETCH, 16'hC000, 8'h00, 1'b0);
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, bmsc_pkg::CC_ROM_ON, 1'b0);
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, bmsc_pkg::CC_BOOT_ON, 1'b0);
        // drive latch walk through 4, 5, 5, 1
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, bmsc_pkg::CC_DRV2_SET, 1'b0);
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, bmsc_pkg::CC_DRV0_SET, 1'b0);
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, bmsc_pkg::CC_DRV1_CLR, 1'b0);
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, bmsc_pkg::CC_DRV2_CLR, 1'b0);
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, bmsc_pkg::CC_SIDE1, 1'b0);
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, bmsc_pkg::CC_MOTOR0, 1'b0);
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, bmsc_pkg::CC_FDC_RESET, 1'b0);
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, 8'h0F, 1'b0);  // first unused code
        queue_txn(bmsc_pkg::OP_CTRL,  16'h0000, 8'hFF, 1'b0);
        queue_txn(bmsc_pkg::OP_LOAD + 3'd1, 16'hFFFF, 8'hFF, 1'b0);  // undefined op
        queue_txn(bmsc_pkg::OP_LOAD + 3'd3, 16'h0000, 8'h00, 1'b0);  // undefined op

        // random mix; every so often the sender waits for a drained pipeline
        for (i = 0; i < RANDOM_TXNS; i++) begin
            r    = $urandom_range(0, 99);
            addr = pick_addr();
            data = 8'($urandom);
            if (r < 25) begin
                op = bmsc_pkg::OP_READ;
            end else if (r < 50) begin
                op = bmsc_pkg::OP_WRITE;
            end else if (r < 70) begin
                op = bmsc_pkg::OP_FETCH;
            end else if (r < 88) begin
                op   = bmsc_pkg::OP_CTRL;
                data = pick_code();
            end else if (r < 97) begin
                op = bmsc_pkg::OP_LOAD;
                if ($urandom_range(0, 3) != 0) begin
                    addr = addr | bmsc_pkg::ROM_BASE;
                end
            end else begin
                op = bmsc_pkg::OP_LOAD + 3'($urandom_range(1, 3));
            end
            queue_txn(op, addr, data, (i % DRAIN_EVERY) == 0);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // all stimulus accepted, then all results in, then an idle wait before the verdict
        while (stim_q.size() != 0 || s_valid) @(posedge aclk);
        while (want_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (err_cnt == 0 && want_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
